// ===== hw/rtl/rfc_pkg.sv =====
// rfc_pkg: shared types, constants and reply byte function for the frame classifier
// used by rfc_front, rfc_queue, rfc_back and rx_frame_classifier_arp_responder
// no dependencies
`default_nettype none

package rfc_pkg;

    localparam logic [15:0] TYPE_ARP  = 16'h0806;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_UDP = 8'h11;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;

    localparam logic [5:0] REPLY_LEN = 6'h2A;
    localparam logic [5:0] PORT_OFS  = 6'h24;
    localparam logic [5:0] PROTO_OFS = 6'h14;

    localparam logic [2:0] V_STORAGE_UDP  = 3'd0;
    localparam logic [2:0] V_ARP_ANSWERED = 3'd1;
    localparam logic [2:0] V_ARP_IGNORED  = 3'd2;
    localparam logic [2:0] V_IPV4_OTHER   = 3'd3;
    localparam logic [2:0] V_UDP_OTHER    = 3'd4;
    localparam logic [2:0] V_TYPE_OTHER   = 3'd5;
    localparam logic [2:0] V_SHORT        = 3'd6;

    localparam logic [1:0] CFG_STATION_MAC  = 2'd0;
    localparam logic [1:0] CFG_STATION_IP   = 2'd1;
    localparam logic [1:0] CFG_STORAGE_PORT = 2'd2;

    localparam logic [31:0] STATION_IP_RESET   = 32'hC0A8010A;
    localparam logic [15:0] STORAGE_PORT_RESET = 16'hBDBD;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [7:0] ARP_FIXED [10] = '{
        8'h08, 8'h06, 8'h00, 8'h01, 8'h08, 8'h00, 8'h06, 8'h04, 8'h00, 8'h02
    };

    typedef struct packed {
        logic [2:0]  verdict;
        logic        answer;
        logic [47:0] requester_mac;
        logic [31:0] requester_ip;
        logic [31:0] asked_ip;
    } rfc_job_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } rfc_queue_status_t;

    function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
        logic [2:0] sel;
        sel = 3'd5 - i;
        return mac[{sel, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
        logic [1:0] sel;
        sel = 2'd3 - i;
        return ip[{sel, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] reply_at(
        input logic [5:0]  idx,
        input logic [47:0] station_mac,
        input rfc_job_t    job
    );
        logic [7:0] b;
        b = 8'h00;
        case (idx) inside
            [6'd0:6'd5]:   b = mac_byte(job.requester_mac, idx[2:0]);
            [6'd6:6'd11]:  b = mac_byte(station_mac, 3'(idx - 6'd6));
            [6'd12:6'd21]: b = ARP_FIXED[4'(idx - 6'd12)];
            [6'd22:6'd27]: b = mac_byte(station_mac, 3'(idx - 6'd22));
            [6'd28:6'd31]: b = ip_byte(job.asked_ip, 2'(idx - 6'd28));
            [6'd32:6'd37]: b = mac_byte(job.requester_mac, 3'(idx - 6'd32));
            [6'd38:6'd41]: b = ip_byte(job.requester_ip, 2'(idx - 6'd38));
            default:       b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rx_frame_classifier_arp_responder.sv =====
// rx_frame_classifier_arp_responder: receive frame classifier with arp reply offload
// depends on rfc_pkg, rfc_front, rfc_queue, rfc_back
//
//   channel   signals                                      direction
//   frame     frame_valid frame_ready frame_byte frame_last  in
//   result    result_valid result_ready out_kind verdict
//             reply_byte run_last                            out
//   cfg       cfg_valid cfg_ready cfg_index cfg_data         in
//
// one frame byte per cycle while the two-entry job queue is not full
// each frame gives one verdict transaction, an answered request 42 more, one per ready cycle
// the output register takes a new transaction in the cycle the previous one is taken
// reset clears the capture state, the queue and the output register; registers take defaults
// a stalled result side backs up into the queue and then holds frame_ready low
`default_nettype none

module rx_frame_classifier_arp_responder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        frame_valid,
    output logic             frame_ready,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        frame_last,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             out_kind,
    output logic [2:0]       verdict,
    output logic [7:0]       reply_byte,
    output logic             run_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    logic [47:0] station_mac_reg;
    logic [31:0] station_ip_reg;
    logic [15:0] storage_port_reg;

    rfc_pkg::rfc_job_t          push_job;
    rfc_pkg::rfc_job_t          head_job;
    rfc_pkg::rfc_queue_status_t q_status;
    logic                       job_push;
    logic                       head_pop;
    logic                       frame_accept;

    assign cfg_ready    = 1'b1;
    assign frame_ready  = !q_status.full;
    assign frame_accept = frame_valid && frame_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_mac_reg  <= '0;
            station_ip_reg   <= rfc_pkg::STATION_IP_RESET;
            storage_port_reg <= rfc_pkg::STORAGE_PORT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rfc_pkg::CFG_STATION_MAC:  station_mac_reg  <= cfg_data;
                rfc_pkg::CFG_STATION_IP:   station_ip_reg   <= cfg_data[31:0];
                rfc_pkg::CFG_STORAGE_PORT: storage_port_reg <= cfg_data[15:0];
                default:                   station_mac_reg  <= station_mac_reg;
            endcase
        end
    end

    rfc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (frame_accept),
        .frame_byte   (frame_byte),
        .frame_last   (frame_last),
        .station_ip   (station_ip_reg),
        .storage_port (storage_port_reg),
        .job          (push_job),
        .job_push     (job_push)
    );

    rfc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (head_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    rfc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .head_valid   (!q_status.empty),
        .head_pop     (head_pop),
        .station_mac  (station_mac_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_kind     (out_kind),
        .verdict      (verdict),
        .reply_byte   (reply_byte),
        .run_last     (run_last)
    );

    // a verdict transaction closes its frame unless a reply follows
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !out_kind |-> run_last == (verdict != rfc_pkg::V_ARP_ANSWERED))
        else $error("verdict transaction run_last mismatch");

    // reply bytes only follow an answered request
    a_reply_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && out_kind |-> verdict == rfc_pkg::V_ARP_ANSWERED)
        else $error("reply byte with wrong verdict");

    // the front never pushes a job while the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> q_status.push)
        else $error("job lost at full queue");

    // every pop loads a transaction into the output register, so result_valid is set after it
    a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.pop |=> result_valid)
        else $error("pop without result transaction");

endmodule

`default_nettype wire

// ===== hw/rtl/rfc_front.sv =====
// rfc_front: byte capture of header fields and end-of-frame classification
// depends on rfc_pkg; pushes one rfc_job_t per frame into rfc_queue
`default_nettype none

module rfc_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     frame_byte,
    input  wire logic           frame_last,
    input  wire logic [31:0]    station_ip,
    input  wire logic [15:0]    storage_port,
    output rfc_pkg::rfc_job_t   job,
    output logic                job_push
);

    logic [5:0]  pos_reg;
    logic [15:0] type_reg;
    logic [7:0]  proto_reg;
    logic [15:0] port_reg;
    logic [15:0] op_reg;
    logic [47:0] rmac_reg;
    logic [31:0] rip_reg;
    logic [31:0] aip_reg;

    logic [5:0]  pos_next;
    logic [15:0] type_next;
    logic [7:0]  proto_next;
    logic [15:0] port_next;
    logic [15:0] op_next;
    logic [47:0] rmac_next;
    logic [31:0] rip_next;
    logic [31:0] aip_next;

    logic [2:0]  verdict;
    logic        answer;

    // fields including the byte on the bus
    always_comb
    begin
        type_next  = type_reg;
        proto_next = proto_reg;
        port_next  = port_reg;
        op_next    = op_reg;
        rmac_next  = rmac_reg;
        rip_next   = rip_reg;
        aip_next   = aip_reg;
        if (pos_reg == 6'd12 || pos_reg == 6'd13)
        begin
            type_next = {type_reg[7:0], frame_byte};
        end
        if (pos_reg == rfc_pkg::PROTO_OFS + 6'd3)
        begin
            proto_next = frame_byte;
        end
        if (pos_reg == rfc_pkg::PORT_OFS || pos_reg == rfc_pkg::PORT_OFS + 6'd1)
        begin
            port_next = {port_reg[7:0], frame_byte};
        end
        if (pos_reg == 6'd20 || pos_reg == 6'd21)
        begin
            op_next = {op_reg[7:0], frame_byte};
        end
        if (pos_reg >= 6'd22 && pos_reg <= 6'd27)
        begin
            rmac_next = {rmac_reg[39:0], frame_byte};
        end
        if (pos_reg >= 6'd28 && pos_reg <= 6'd31)
        begin
            rip_next = {rip_reg[23:0], frame_byte};
        end
        if (pos_reg >= 6'd38 && pos_reg <= 6'd41)
        begin
            aip_next = {aip_reg[23:0], frame_byte};
        end
    end

    assign pos_next = (pos_reg == 6'd63) ? pos_reg : pos_reg + 6'd1;

    // frame length is pos_reg + 1 up to 64 bytes, where pos_reg saturates at 63
    always_comb
    begin
        answer  = 1'b0;
        verdict = rfc_pkg::V_TYPE_OTHER;
        if (pos_reg < 6'd13)
        begin
            verdict = rfc_pkg::V_SHORT;
        end
        else if (type_next == rfc_pkg::TYPE_ARP)
        begin
            if (pos_reg < 6'd41)
            begin
                verdict = rfc_pkg::V_SHORT;
            end
            else if (op_next == rfc_pkg::ARP_OP_REQUEST && aip_next == station_ip)
            begin
                verdict = rfc_pkg::V_ARP_ANSWERED;
                answer  = 1'b1;
            end
            else
            begin
                verdict = rfc_pkg::V_ARP_IGNORED;
            end
        end
        else if (type_next == rfc_pkg::TYPE_IPV4)
        begin
            if (pos_reg < 6'd23)
            begin
                verdict = rfc_pkg::V_SHORT;
            end
            else if (proto_next != rfc_pkg::PROTO_UDP)
            begin
                verdict = rfc_pkg::V_IPV4_OTHER;
            end
            else if (pos_reg < 6'd37)
            begin
                verdict = rfc_pkg::V_SHORT;
            end
            else if (port_next == storage_port)
            begin
                verdict = rfc_pkg::V_STORAGE_UDP;
            end
            else
            begin
                verdict = rfc_pkg::V_UDP_OTHER;
            end
        end
    end

    assign job.verdict       = verdict;
    assign job.answer        = answer;
    assign job.requester_mac = rmac_next;
    assign job.requester_ip  = rip_next;
    assign job.asked_ip      = aip_next;
    assign job_push          = accept && frame_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            type_reg  <= '0;
            proto_reg <= '0;
            port_reg  <= '0;
            op_reg    <= '0;
            rmac_reg  <= '0;
            rip_reg   <= '0;
            aip_reg   <= '0;
        end
        else if (accept)
        begin
            if (frame_last)
            begin
                pos_reg   <= '0;
                type_reg  <= '0;
                proto_reg <= '0;
                port_reg  <= '0;
                op_reg    <= '0;
                rmac_reg  <= '0;
                rip_reg   <= '0;
                aip_reg   <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                type_reg  <= type_next;
                proto_reg <= proto_next;
                port_reg  <= port_next;
                op_reg    <= op_next;
                rmac_reg  <= rmac_next;
                rip_reg   <= rip_next;
                aip_reg   <= aip_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rfc_queue.sv =====
// rfc_queue: two-entry job queue between classifier front and reply back end
// depends on rfc_pkg
`default_nettype none

module rfc_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire rfc_pkg::rfc_job_t   push_job,
    input  wire logic                pop,
    output rfc_pkg::rfc_job_t        head_job,
    output rfc_pkg::rfc_queue_status_t status
);

    rfc_pkg::rfc_job_t             entry_reg [rfc_pkg::QUEUE_DEPTH];
    logic [rfc_pkg::QUEUE_AW-1:0]  wr_ptr_reg;
    logic [rfc_pkg::QUEUE_AW-1:0]  rd_ptr_reg;
    logic [rfc_pkg::QUEUE_AW:0]    count_reg;
    logic                          do_push;
    logic                          do_pop;

    assign status.full  = (count_reg == (rfc_pkg::QUEUE_AW + 1)'(rfc_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign status.push  = do_push;
    assign status.pop   = do_pop;
    assign head_job     = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rfc_back.sv =====
// rfc_back: emits the verdict item and, for answered requests, the arp reply bytes
// depends on rfc_pkg; reads jobs from rfc_queue head
`default_nettype none

module rfc_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rfc_pkg::rfc_job_t head_job,
    input  wire logic           head_valid,
    output logic                head_pop,
    input  wire logic [47:0]    station_mac,
    output logic                result_valid,
    input  wire logic           result_ready,
    output logic                out_kind,
    output logic [2:0]          verdict,
    output logic [7:0]          reply_byte,
    output logic                run_last
);

    logic       valid_reg;
    logic [5:0] step_reg;
    logic       kind_reg;
    logic [2:0] verdict_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;
    logic       item_last;
    logic [5:0] reply_idx;

    assign load      = head_valid && (!valid_reg || result_ready);
    assign reply_idx = step_reg - 6'd1;
    assign item_last = (step_reg == 6'd0) ? !head_job.answer : (step_reg == rfc_pkg::REPLY_LEN);
    assign head_pop  = load && item_last;

    assign result_valid = valid_reg;
    assign out_kind     = kind_reg;
    assign verdict      = verdict_reg;
    assign reply_byte   = byte_reg;
    assign run_last     = last_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            last_reg <= item_last;
            if (step_reg == 6'd0)
            begin
                kind_reg    <= 1'b0;
                verdict_reg <= head_job.verdict;
                byte_reg    <= 8'h00;
            end
            else
            begin
                kind_reg    <= 1'b1;
                verdict_reg <= rfc_pkg::V_ARP_ANSWERED;
                byte_reg    <= rfc_pkg::reply_at(reply_idx, station_mac, head_job);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                step_reg  <= item_last ? 6'd0 : step_reg + 6'd1;
            end
            else if (result_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking testbench for rx_frame_classifier_arp_responder
// drives well-formed and broken frames, predicts verdicts and arp replies, checks every result
// depends on rfc_pkg and the classifier rtl

module tb_top;
    import rfc_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 3;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_STALL      = 9;
    localparam int MAX_PRINTS     = 50;
    localparam int NO_TYPED       = -1;

    localparam logic [6:0]  MIN_ETH_LEN  = 7'd14;
    localparam logic [6:0]  MIN_IPV4_LEN = 7'd24;
    localparam logic [6:0]  MIN_UDP_LEN  = 7'd38;
    localparam logic [6:0]  MIN_ARP_LEN  = 7'd42;
    localparam int          ARP_REPLY_BYTES = 42;
    localparam logic [15:0] HW_ETHERNET  = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY = 16'h0002;
    localparam logic [7:0]  MAC_ADDR_LEN = 8'd6;
    localparam logic [7:0]  IP_ADDR_LEN  = 8'd4;
    localparam logic [3:0]  NO_WANT      = 4'hF;

    typedef enum logic [3:0] {
        FK_ARP_REQ,
        FK_ARP_MISS,
        FK_ARP_OP,
        FK_UDP_STORE,
        FK_UDP_OTHER,
        FK_IPV4_OTHER,
        FK_TYPE_OTHER,
        FK_NOISE
    } frame_kind_e;

    typedef struct packed {
        frame_kind_e kind;
        logic [7:0]  len;
        logic [3:0]  want;
    } dir_row_t;

    typedef struct packed {
        logic       kind;
        logic [2:0] verdict;
        logic [7:0] rbyte;
        logic       last;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        frame_valid = 1'b0;
    logic        frame_ready;
    logic [7:0]  frame_byte = 8'h00;
    logic        frame_last = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic        out_kind;
    logic [2:0]  verdict;
    logic [7:0]  reply_byte;
    logic        run_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_STATION_MAC;
    logic [47:0] cfg_data = 48'h0;

    // predictor copy of the settings and of the per-frame capture
    logic [47:0] my_mac  = 48'h0;
    logic [31:0] my_ip   = STATION_IP_RESET;
    logic [15:0] my_port = STORAGE_PORT_RESET;
    logic [5:0]  cur_pos = 6'd0;
    logic [15:0] cur_type = 16'h0;
    logic [7:0]  cur_proto = 8'h0;
    logic [15:0] cur_port = 16'h0;
    logic [15:0] cur_op = 16'h0;
    logic [47:0] cur_src_mac = 48'h0;
    logic [31:0] cur_src_ip = 32'h0;
    logic [31:0] cur_asked_ip = 32'h0;

    result_t     expected_results [$];
    int          typed_q [$];
    dir_row_t    dir_rows [8];
    logic [7:0]  frame_buf [0:127];

    int errors = 0;
    int results_seen = 0;
    int bytes_seen = 0;
    int frames_seen = 0;
    int replies_predicted = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;
    int sink_wait = 0;
    logic sink_calm = 1'b0;

    always #CLK_HALF clk = ~clk;

    rx_frame_classifier_arp_responder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame_byte   (frame_byte),
        .frame_last   (frame_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_kind     (out_kind),
        .verdict      (verdict),
        .reply_byte   (reply_byte),
        .run_last     (run_last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    task automatic report(input string msg);
        if (errors < MAX_PRINTS)
            $display("%0t mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    // capture one accepted byte; on the last byte queue the verdict and any arp reply
    task automatic classify_byte(input logic [7:0] b, input logic last);
        logic [6:0]   len;
        logic [2:0]   v;
        logic         answer;
        logic [335:0] reply;
        int           want;
        result_t      item;
        len = {1'b0, cur_pos} + 7'd1;
        if (cur_pos == 6'd12 || cur_pos == 6'd13)
            cur_type = {cur_type[7:0], b};
        if (cur_pos == 6'd23)
            cur_proto = b;
        if (cur_pos == 6'd36 || cur_pos == 6'd37)
            cur_port = {cur_port[7:0], b};
        if (cur_pos == 6'd20 || cur_pos == 6'd21)
            cur_op = {cur_op[7:0], b};
        if (cur_pos >= 6'd22 && cur_pos <= 6'd27)
            cur_src_mac = {cur_src_mac[39:0], b};
        if (cur_pos >= 6'd28 && cur_pos <= 6'd31)
            cur_src_ip = {cur_src_ip[23:0], b};
        if (cur_pos >= 6'd38 && cur_pos <= 6'd41)
            cur_asked_ip = {cur_asked_ip[23:0], b};
        if (cur_pos != 6'd63)
            cur_pos = cur_pos + 6'd1;
        if (!last)
            return;

        answer = 1'b0;
        if (len < MIN_ETH_LEN)
            v = V_SHORT;
        else if (cur_type == TYPE_ARP)
        begin
            if (len < MIN_ARP_LEN)
                v = V_SHORT;
            else if (cur_op == ARP_OP_REQUEST && cur_asked_ip == my_ip)
            begin
                v = V_ARP_ANSWERED;
                answer = 1'b1;
            end
            else
                v = V_ARP_IGNORED;
        end
        else if (cur_type == TYPE_IPV4)
        begin
            if (len < MIN_IPV4_LEN)
                v = V_SHORT;
            else if (cur_proto != PROTO_UDP)
                v = V_IPV4_OTHER;
            else if (len < MIN_UDP_LEN)
                v = V_SHORT;
            else if (cur_port == my_port)
                v = V_STORAGE_UDP;
            else
                v = V_UDP_OTHER;
        end
        else
            v = V_TYPE_OTHER;

        want = NO_TYPED;
        if (typed_q.size() != 0)
            want = typed_q.pop_front();
        item.kind = 1'b0;
        item.verdict = (want == NO_TYPED) ? v : 3'(want);
        item.rbyte = 8'h00;
        item.last = !answer;
        expected_results.push_back(item);

        if (answer)
        begin
            reply = {cur_src_mac, my_mac, TYPE_ARP, HW_ETHERNET, TYPE_IPV4, MAC_ADDR_LEN,
                     IP_ADDR_LEN, ARP_OP_REPLY, my_mac, cur_asked_ip, cur_src_mac, cur_src_ip};
            for (int i = 0; i < ARP_REPLY_BYTES; i++)
            begin
                item.kind = 1'b1;
                item.verdict = V_ARP_ANSWERED;
                item.rbyte = reply[335 - 8 * i -: 8];
                item.last = (i == ARP_REPLY_BYTES - 1);
                expected_results.push_back(item);
            end
            replies_predicted++;
        end

        cur_pos = 6'd0;
        cur_type = 16'h0;
        cur_proto = 8'h0;
        cur_port = 16'h0;
        cur_op = 16'h0;
        cur_src_mac = 48'h0;
        cur_src_ip = 32'h0;
        cur_asked_ip = 32'h0;
    endtask

    // prediction, result checking and watchdog
    always @(posedge clk)
    begin : monitor
        result_t exp_item;
        if (rst_n)
        begin
            if (frame_valid && frame_ready)
            begin
                bytes_seen++;
                if (frame_last)
                    frames_seen++;
                classify_byte(frame_byte, frame_last);
            end
            if (result_valid && result_ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                    report($sformatf("unexpected transaction kind %0d verdict %0d byte %0h last %0d",
                                     out_kind, verdict, reply_byte, run_last));
                else
                begin
                    exp_item = expected_results.pop_front();
                    check_field("out_kind", out_kind, exp_item.kind);
                    check_field("verdict", verdict, exp_item.verdict);
                    check_field("reply_byte", reply_byte, exp_item.rbyte);
                    check_field("run_last", run_last, exp_item.last);
                end
            end
            if ((frame_valid && frame_ready) || (result_valid && result_ready)
                || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // result side backpressure
    always @(posedge clk or negedge rst_n)
    begin : sink
        int stall;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            sink_wait <= 0;
            sink_calm <= 1'b0;
        end
        else if (sink_wait != 0)
        begin
            sink_wait <= sink_wait - 1;
            result_ready <= (sink_wait == 1);
        end
        else if (result_valid && result_ready)
        begin
            stall = sink_calm ? 0 : $urandom_range(0, MAX_STALL);
            if ($urandom_range(0, 39) == 0)
                sink_calm <= !sink_calm;
            sink_wait <= stall;
            result_ready <= (stall == 0);
        end
        else
            result_ready <= 1'b1;
    end

    task automatic push_byte(input logic [7:0] b, input logic last, input int gap);
        if (gap != 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame_byte <= b;
        frame_last <= last;
        do @(posedge clk); while (!frame_ready);
    endtask

    task automatic wait_drained();
        frame_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [1:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_STATION_MAC:  my_mac = data;
            CFG_STATION_IP:   my_ip = data[31:0];
            CFG_STORAGE_PORT: my_port = data[15:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic write_settings(input logic [47:0] mac_data, input logic [47:0] ip_data,
                                  input logic [47:0] port_data);
        cfg_put(CFG_STATION_MAC, mac_data);
        cfg_put(CFG_STATION_IP, ip_data);
        cfg_put(CFG_STORAGE_PORT, port_data);
        cfg_valid <= 1'b0;
    endtask

    task automatic build_frame(input frame_kind_e kind);
        logic [15:0] etype;
        logic [15:0] op;
        logic [15:0] port;
        logic [7:0]  proto;
        logic [31:0] target;
        for (int k = 0; k < 128; k++)
            frame_buf[k] = 8'($urandom);
        etype = 16'($urandom);
        case (kind)
            FK_ARP_REQ, FK_ARP_MISS, FK_ARP_OP:
            begin
                etype = TYPE_ARP;
                op = ARP_OP_REQUEST;
                target = my_ip;
                if (kind == FK_ARP_OP)
                begin
                    op = 16'($urandom);
                    if (op == ARP_OP_REQUEST)
                        op = ARP_OP_REPLY;
                end
                if (kind == FK_ARP_MISS)
                begin
                    target = $urandom;
                    if (target == my_ip)
                        target = ~my_ip;
                end
                frame_buf[20] = op[15:8];
                frame_buf[21] = op[7:0];
                {frame_buf[38], frame_buf[39], frame_buf[40], frame_buf[41]} = target;
            end
            FK_UDP_STORE, FK_UDP_OTHER, FK_IPV4_OTHER:
            begin
                etype = TYPE_IPV4;
                proto = PROTO_UDP;
                port = my_port;
                if (kind == FK_UDP_OTHER)
                begin
                    port = 16'($urandom);
                    if (port == my_port)
                        port = ~my_port;
                end
                if (kind == FK_IPV4_OTHER)
                begin
                    proto = 8'($urandom);
                    if (proto == PROTO_UDP)
                        proto = ~PROTO_UDP;
                end
                frame_buf[23] = proto;
                frame_buf[36] = port[15:8];
                frame_buf[37] = port[7:0];
            end
            FK_TYPE_OTHER:
                if (etype == TYPE_ARP || etype == TYPE_IPV4)
                    etype = ~etype;
            default: ;
        endcase
        if (kind != FK_NOISE)
        begin
            frame_buf[12] = etype[15:8];
            frame_buf[13] = etype[7:0];
        end
    endtask

    task automatic send_frame(input frame_kind_e kind, input int len, input int want);
        logic calm;
        build_frame(kind);
        typed_q.push_back(want);
        calm = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++)
            push_byte(frame_buf[k], k == len - 1, calm ? 0 : $urandom_range(0, MAX_STALL));
    endtask

    function automatic frame_kind_e pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return FK_ARP_REQ;
        if (r < 35) return FK_ARP_MISS;
        if (r < 45) return FK_ARP_OP;
        if (r < 60) return FK_UDP_STORE;
        if (r < 70) return FK_UDP_OTHER;
        if (r < 80) return FK_IPV4_OTHER;
        if (r < 90) return FK_TYPE_OTHER;
        return FK_NOISE;
    endfunction

    function automatic int pick_len(input frame_kind_e kind);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return $urandom_range(1, 45);
        if (r == 1)
            return $urandom_range(64, 100);
        case (kind)
            FK_ARP_REQ, FK_ARP_MISS, FK_ARP_OP: return $urandom_range(42, 60);
            FK_UDP_STORE, FK_UDP_OTHER:         return $urandom_range(38, 64);
            FK_IPV4_OTHER:                      return $urandom_range(24, 64);
            default:                            return $urandom_range(14, 64);
        endcase
    endfunction

    task automatic run_phase(input int min_bytes, input int min_frames);
        int          nbytes;
        int          nframes;
        int          len;
        frame_kind_e kind;
        nbytes = 0;
        nframes = 0;
        while (nbytes < min_bytes || nframes < min_frames)
        begin
            kind = pick_kind();
            len = pick_len(kind);
            send_frame(kind, len, NO_TYPED);
            nbytes += len;
            nframes++;
            if ($urandom_range(0, 5) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin : stimulus
        dir_row_t row;
        int       want;
        // verdict boundaries and one frame past the position saturation, under the reset settings
        dir_rows[0]  = '{FK_NOISE,      8'd1,   {1'b0, V_SHORT}};
        dir_rows[1]  = '{FK_TYPE_OTHER, 8'd13,  {1'b0, V_SHORT}};
        dir_rows[2]  = '{FK_TYPE_OTHER, 8'd14,  {1'b0, V_TYPE_OTHER}};
        dir_rows[3]  = '{FK_ARP_REQ,    8'd41,  {1'b0, V_SHORT}};
        dir_rows[4]  = '{FK_ARP_REQ,    8'd42,  NO_WANT};
        dir_rows[5]  = '{FK_UDP_STORE,  8'd37,  {1'b0, V_SHORT}};
        dir_rows[6]  = '{FK_UDP_STORE,  8'd38,  {1'b0, V_STORAGE_UDP}};
        dir_rows[7]  = '{FK_UDP_OTHER,  8'd65,  {1'b0, V_UDP_OTHER}};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            want = (row.want == NO_WANT) ? NO_TYPED : int'(row.want);
            send_frame(row.kind, int'(row.len), want);
        end
        wait_drained();

        write_settings(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        run_phase(1, 1);
        write_settings({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                       {16'($urandom), 32'($urandom)});
        run_phase(1, 1);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            report($sformatf("%0d expected transactions never arrived", expected_results.size()));

        $display("covered %0d frames (%0d bytes) giving %0d result transactions, %0d arp replies",
                 frames_seen, bytes_seen, results_seen, replies_predicted);
        $display("station settings changed by %0d register writes, %0d mismatches",
                 cfg_writes, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== rx_frame_classifier_arp_responder.f =====
hw/rtl/rfc_pkg.sv
hw/rtl/rfc_front.sv
hw/rtl/rfc_queue.sv
hw/rtl/rfc_back.sv
hw/rtl/rx_frame_classifier_arp_responder.sv
tb/tb_top.sv
